FILE: rtl/fcfl_pkg.sv
// ----------------------------------------------------------------------------
// fcfl_pkg: shared types and codes for the fixed chunk free list
// Item kinds, result status codes, register map, engine states and the
// configuration bundle passed from the register block to the engine.
// ----------------------------------------------------------------------------
package fcfl_pkg;

   // Payload widths
   localparam int OFFSET_W = 24;
   localparam int LENGTH_W = 25;
   localparam int SHIFT_W  = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Item kinds
   localparam logic [1:0] KIND_ALLOC    = 2'd0;
   localparam logic [1:0] KIND_FREE     = 2'd1;
   localparam logic [1:0] KIND_FREE_ALL = 2'd2;

   // Result status
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_EMPTY  = 2'd1;
   localparam logic [1:0] STATUS_BOUNDS = 2'd2;

   // Register index, taken from paddr bit 2
   localparam logic REG_BUFFER_LENGTH = 1'b0;
   localparam logic REG_CHUNK_SHIFT   = 1'b1;

   // Chunk shift limits and reset value
   localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 5'd3;
   localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd16;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ALLOC_WAIT,
      ST_SWEEP
   } fcfl_state_type;

   typedef struct packed {
      logic [LENGTH_W-1:0] buffer_length;
      logic [SHIFT_W-1:0]  chunk_shift;
   } fcfl_cfg_type;

   // Clamp the programmed shift into the supported range
   function automatic logic [SHIFT_W-1:0] clamp_shift(input logic [SHIFT_W-1:0] s);
      logic [SHIFT_W-1:0] r;
      r = s;
      if (s < SHIFT_MIN) begin
         r = SHIFT_MIN;
      end else if (s > SHIFT_MAX) begin
         r = SHIFT_MAX;
      end
      return r;
   endfunction

endpackage

FILE: rtl/fcfl_if.sv
// ----------------------------------------------------------------------------
// fcfl_if: request and response channel interfaces
// Valid/ready channels; a beat moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface fcfl_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [23:0] byte_offset;

   modport source (output valid, kind, byte_offset, input ready);
   modport sink   (input valid, kind, byte_offset, output ready);
endinterface

interface fcfl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [23:0] chunk_offset;

   modport source (output valid, status, chunk_offset, input ready);
   modport sink   (input valid, status, chunk_offset, output ready);
endinterface

FILE: rtl/fixed_chunk_free_list.sv
// ----------------------------------------------------------------------------
// fixed_chunk_free_list: fixed-size chunk pool manager
// Usage: each request beat on req_ch (kind, byte_offset) yields exactly one
// response beat on rsp_ch (status, chunk_offset), in order.
//   alloc    pops the free-list head; the response loads the cycle after the
//            registered link read; no new request is taken meanwhile.
//   free     pushes the chunk holding byte_offset; one per cycle unless stalled.
//   free-all rebuilds the list over min(buffer_length >> chunk_shift,
//            MAX_CHUNKS) chunks, writing one link per cycle; the response
//            is issued at once, with no new request taken until the sweep ends.
// Registers on the csr_ APB port: buffer_length at 0x0, chunk_shift at 0x4;
// write only while no item is in flight.
// Reset empties the list and sets buffer_length 0, chunk_shift 6; the link
// memory needs no clearing pass.
// A response waits in an output register while rsp_ch.ready is low; no new
// request is taken until that register is free or being drained.
// ----------------------------------------------------------------------------
module fixed_chunk_free_list
   import fcfl_pkg::*;
#(
   parameter int MAX_CHUNKS = 256
)(
   input  logic                  clock,
   input  logic                  reset,
   fcfl_req_if.sink              req_ch,
   fcfl_rsp_if.source            rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   fcfl_cfg_type cfg;

   fcfl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fcfl_engine #(
      .MAX_CHUNKS (MAX_CHUNKS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule

FILE: rtl/fcfl_csr.sv
// ----------------------------------------------------------------------------
// fcfl_csr: configuration registers
// APB-style write/read of buffer_length and chunk_shift; no wait states.
// ----------------------------------------------------------------------------
module fcfl_csr
   import fcfl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output fcfl_cfg_type          cfg
);

   logic [LENGTH_W-1:0] buffer_length_ff, buffer_length_in;
   logic [SHIFT_W-1:0]  chunk_shift_ff, chunk_shift_in;
   logic                wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   // Write decode
   always_comb begin
      buffer_length_in = buffer_length_ff;
      chunk_shift_in   = chunk_shift_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            REG_BUFFER_LENGTH: buffer_length_in = csr_pwdata[LENGTH_W-1:0];
            REG_CHUNK_SHIFT:   chunk_shift_in   = csr_pwdata[SHIFT_W-1:0];
            default:           buffer_length_in = buffer_length_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_length_ff <= '0;
         chunk_shift_ff   <= SHIFT_RESET;
      end else begin
         buffer_length_ff <= buffer_length_in;
         chunk_shift_ff   <= chunk_shift_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (csr_paddr[2])
         REG_BUFFER_LENGTH: csr_prdata = CSR_DATA_W'(buffer_length_ff);
         REG_CHUNK_SHIFT:   csr_prdata = CSR_DATA_W'(chunk_shift_ff);
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg.buffer_length = buffer_length_ff;
   assign cfg.chunk_shift   = chunk_shift_ff;

endmodule

FILE: rtl/fcfl_engine.sv
// ----------------------------------------------------------------------------
// fcfl_engine: free list engine
// Head register plus next-link memory; pop, push and rebuild sweep, with a
// registered response stage.
// ----------------------------------------------------------------------------
module fcfl_engine
   import fcfl_pkg::*;
#(
   parameter int MAX_CHUNKS = 256
)(
   input  logic         clock,
   input  logic         reset,
   input  fcfl_cfg_type cfg,
   fcfl_req_if.sink     req_ch,
   fcfl_rsp_if.source   rsp_ch
);

   localparam int IDX_W    = $clog2(MAX_CHUNKS);
   localparam int LINK_W   = IDX_W + 1;
   localparam int CNT_W    = IDX_W + 1;
   localparam int WIDE_W   = IDX_W + 16;
   localparam logic [LINK_W-1:0] LINK_END = LINK_W'(MAX_CHUNKS);

   // Control and response registers
   fcfl_state_type      state_ff, state_in;
   logic [IDX_W-1:0]    head_index_ff, head_index_in;
   logic                head_valid_ff, head_valid_in;
   logic [CNT_W-1:0]    sweep_ff, sweep_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;

   // Link memory
   logic [LINK_W-1:0] link_mem [MAX_CHUNKS];
   logic [LINK_W-1:0] rd_data_ff;
   logic              mem_wr_en, mem_rd_en;
   logic [IDX_W-1:0]  mem_wr_addr;
   logic [LINK_W-1:0] mem_wr_data;

   logic                accept;
   logic [SHIFT_W-1:0]  shift;
   logic [OFFSET_W-1:0] free_idx;
   logic                free_ok;
   logic [LENGTH_W-1:0] len_chunks;
   logic [CNT_W-1:0]    new_count;
   logic [WIDE_W-1:0]   alloc_wide;
   logic                sweep_last;

   assign req_ch.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;
   assign shift        = clamp_shift(cfg.chunk_shift);

   // Free bounds check
   assign free_idx = req_ch.byte_offset >> shift;
   assign free_ok  = ({1'b0, req_ch.byte_offset} < cfg.buffer_length) &&
                     ({1'b0, free_idx} < LENGTH_W'(MAX_CHUNKS));

   // Chunk count for rebuild, capped at storage
   assign len_chunks = cfg.buffer_length >> shift;
   assign new_count  = (len_chunks > LENGTH_W'(MAX_CHUNKS)) ? CNT_W'(MAX_CHUNKS)
                                                            : len_chunks[CNT_W-1:0];

   assign alloc_wide = WIDE_W'(head_index_ff) << shift;
   assign sweep_last = (sweep_ff == count_ff - CNT_W'(1));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_ch.kind == KIND_ALLOC && head_valid_ff) begin
               state_in = ST_ALLOC_WAIT;
            end else if (accept && req_ch.kind == KIND_FREE_ALL && new_count != '0) begin
               state_in = ST_SWEEP;
            end
         end
         ST_ALLOC_WAIT: state_in = ST_IDLE;
         ST_SWEEP: begin
            if (sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory control
   always_comb begin
      head_index_in = head_index_ff;
      head_valid_in = head_valid_ff;
      sweep_in      = sweep_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = free_idx[IDX_W-1:0];
      mem_wr_data   = head_valid_ff ? LINK_W'(head_index_ff) : LINK_END;
      mem_rd_en     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_offset_in = '0;
               case (req_ch.kind)
                  KIND_ALLOC: begin
                     if (head_valid_ff) begin
                        // response loads once the link read returns
                        rsp_valid_in = 1'b0;
                        mem_rd_en    = 1'b1;
                     end else begin
                        rsp_status_in = STATUS_EMPTY;
                     end
                  end
                  KIND_FREE: begin
                     if (free_ok) begin
                        mem_wr_en     = 1'b1;
                        head_index_in = free_idx[IDX_W-1:0];
                        head_valid_in = 1'b1;
                     end else begin
                        rsp_status_in = STATUS_BOUNDS;
                     end
                  end
                  KIND_FREE_ALL: begin
                     count_in = new_count;
                     sweep_in = '0;
                     if (new_count == '0) begin
                        head_index_in = '0;
                        head_valid_in = 1'b0;
                     end else begin
                        head_index_in = IDX_W'(new_count - CNT_W'(1));
                        head_valid_in = 1'b1;
                     end
                  end
                  default: rsp_status_in = STATUS_OK;
               endcase
            end
         end
         ST_ALLOC_WAIT: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_offset_in = OFFSET_W'(alloc_wide);
            if (rd_data_ff < LINK_END) begin
               head_index_in = rd_data_ff[IDX_W-1:0];
               head_valid_in = 1'b1;
            end else begin
               head_index_in = '0;
               head_valid_in = 1'b0;
            end
         end
         ST_SWEEP: begin
            // chunk 0 ends the list, every other chunk links one down
            mem_wr_en   = 1'b1;
            mem_wr_addr = sweep_ff[IDX_W-1:0];
            mem_wr_data = (sweep_ff == '0) ? LINK_END : LINK_W'(sweep_ff - CNT_W'(1));
            sweep_in    = sweep_ff + CNT_W'(1);
         end
         default: rsp_valid_in = rsp_valid_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_index_ff <= '0;
         head_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_index_ff <= head_index_in;
         head_valid_ff <= head_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sweep_ff      <= sweep_in;
      count_ff      <= count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   // Link memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         link_mem[mem_wr_addr] <= mem_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         rd_data_ff <= link_mem[head_index_ff];
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.chunk_offset = rsp_offset_ff;

endmodule

FILE: dv/fixed_chunk_free_list_test.sv
// ----------------------------------------------------------------------------
// fixed_chunk_free_list_test: self-checking bench for the chunk pool free list
// Drives alloc, free, free-all and unused-kind beats into the pool under
// several register settings and idle/stall patterns. A predictor keeps its own
// copy of the head, the link memory and the registers, and every response
// beat is compared in order against the predicted status and chunk offset.
// ----------------------------------------------------------------------------
module fixed_chunk_free_list_test;
   import fcfl_pkg::*;

   localparam int POOL_CHUNKS = 256;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] ADDR_BUFFER_LENGTH = {REG_BUFFER_LENGTH, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_CHUNK_SHIFT   = {REG_CHUNK_SHIFT, 2'b00};
   // free-all sweep plus margin; the response leaves before the sweep ends
   localparam int SETTLE_CYCLES = POOL_CHUNKS + 16;

   typedef struct packed {
      logic [1:0]          status;
      logic [OFFSET_W-1:0] chunk_offset;
   } pool_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   fcfl_req_if req_ch();
   fcfl_rsp_if rsp_ch();

   fixed_chunk_free_list #(
      .MAX_CHUNKS(POOL_CHUNKS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Predicted pool state and register copy
   fcfl_cfg_type pool_cfg = '{buffer_length: '0, chunk_shift: SHIFT_RESET};
   logic [7:0]   pool_head = '0;
   logic         pool_head_vld = 1'b0;
   logic [8:0]   pool_link [POOL_CHUNKS] = '{default: '0};

   pool_result_type     outcome_q[$];
   logic [OFFSET_W-1:0] held_chunks[$];
   logic [OFFSET_W-1:0] freed_chunks[$];
   int fail_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;

   // Clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [SHIFT_W-1:0] clamp_chunk_shift(logic [SHIFT_W-1:0] s);
      if (s < SHIFT_MIN) begin
         return SHIFT_MIN;
      end
      if (s > SHIFT_MAX) begin
         return SHIFT_MAX;
      end
      return s;
   endfunction

   // Apply one beat to the predicted pool, return its response
   function automatic pool_result_type pool_outcome(logic [1:0] kind,
                                                    logic [OFFSET_W-1:0] off);
      pool_result_type     r;
      logic [SHIFT_W-1:0]  sh;
      logic [31:0]         wide;
      logic [8:0]          nxt;
      logic [OFFSET_W-1:0] idx;
      int                  count;
      r = '0;
      sh = clamp_chunk_shift(pool_cfg.chunk_shift);
      case (kind)
         KIND_ALLOC: begin
            if (pool_head_vld) begin
               wide = 32'(pool_head) << sh;
               r.chunk_offset = wide[OFFSET_W-1:0];
               nxt = pool_link[pool_head];
               if (nxt < POOL_CHUNKS) begin
                  pool_head = nxt[7:0];
               end else begin
                  pool_head = '0;
                  pool_head_vld = 1'b0;
               end
            end else begin
               r.status = STATUS_EMPTY;
            end
         end
         KIND_FREE: begin
            idx = off >> sh;
            if (LENGTH_W'(off) >= pool_cfg.buffer_length || idx >= POOL_CHUNKS) begin
               r.status = STATUS_BOUNDS;
            end else begin
               pool_link[idx] = pool_head_vld ? {1'b0, pool_head} : 9'(POOL_CHUNKS);
               pool_head = idx[7:0];
               pool_head_vld = 1'b1;
            end
         end
         KIND_FREE_ALL: begin
            count = int'(pool_cfg.buffer_length >> sh);
            if (count > POOL_CHUNKS) begin
               count = POOL_CHUNKS;
            end
            for (int i = 0; i < count; i++) begin
               pool_link[i] = (i == 0) ? 9'(POOL_CHUNKS) : 9'(i - 1);
            end
            if (count == 0) begin
               pool_head = '0;
               pool_head_vld = 1'b0;
            end else begin
               pool_head = 8'(count - 1);
               pool_head_vld = 1'b1;
            end
         end
         default: begin
            // unused kind leaves the pool alone
         end
      endcase
      return r;
   endfunction

   // Response sink: random stalls, or a long hold when requested
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Compare each response beat against the oldest prediction
   always @(posedge clock) begin
      pool_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (outcome_q.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected response beat, expected none got status %0d offset 0x%06h",
                     $time, rsp_ch.status, rsp_ch.chunk_offset);
         end else begin
            want = outcome_q.pop_front();
            if (rsp_ch.status !== want.status) begin
               fail_count++;
               $display("%0t: status mismatch, expected %0d got %0d",
                        $time, want.status, rsp_ch.status);
            end
            if (rsp_ch.chunk_offset !== want.chunk_offset) begin
               fail_count++;
               $display("%0t: chunk_offset mismatch, expected 0x%06h got 0x%06h",
                        $time, want.chunk_offset, rsp_ch.chunk_offset);
            end
         end
      end
   end

   // One request beat, after a random idle gap
   task automatic send_item(input logic [1:0] kind, input logic [OFFSET_W-1:0] off,
                            output pool_result_type res);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.kind        <= kind;
      req_ch.byte_offset <= off;
      do @(posedge clock); while (!req_ch.ready);
      res = pool_outcome(kind, off);
      outcome_q.push_back(res);
   endtask

   task automatic send_beat(input logic [1:0] kind, input logic [OFFSET_W-1:0] off);
      pool_result_type res;
      send_item(kind, off, res);
   endtask

   // Drain all responses and let any free-all sweep finish
   task automatic wait_quiet();
      req_ch.valid <= 1'b0;
      while (outcome_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(input logic [CSR_ADDR_W-1:0] addr, output logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      data = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Program both registers while idle, then read them back
   task automatic set_pool(input logic [LENGTH_W-1:0] len, input logic [SHIFT_W-1:0] shift);
      logic [CSR_DATA_W-1:0] rd;
      wait_quiet();
      csr_write(ADDR_BUFFER_LENGTH, CSR_DATA_W'(len));
      csr_write(ADDR_CHUNK_SHIFT, CSR_DATA_W'(shift));
      pool_cfg.buffer_length = len;
      pool_cfg.chunk_shift = shift;
      held_chunks.delete();
      freed_chunks.delete();
      csr_read(ADDR_BUFFER_LENGTH, rd);
      if (rd[LENGTH_W-1:0] !== len) begin
         fail_count++;
         $display("%0t: buffer_length readback, expected 0x%07h got 0x%07h",
                  $time, len, rd[LENGTH_W-1:0]);
      end
      csr_read(ADDR_CHUNK_SHIFT, rd);
      if (rd[SHIFT_W-1:0] !== shift) begin
         fail_count++;
         $display("%0t: chunk_shift readback, expected %0d got %0d",
                  $time, shift, rd[SHIFT_W-1:0]);
      end
   endtask

   // Pool left at reset: zero length, so nothing can be freed or allocated
   task automatic test_reset_pool();
      send_beat(KIND_ALLOC, '0);
      send_beat(KIND_FREE, '0);
      send_beat(KIND_FREE, 24'hFFFFFF);
      send_beat(KIND_FREE_ALL, '0);
      send_beat(KIND_ALLOC, '0);
      send_beat(KIND_UNUSED, 24'hFFFFFF);
   endtask

   // Two-chunk pool: exhaustion, unaligned free, bounds, double free
   task automatic test_small_pool();
      set_pool(25'd128, 5'd6);
      send_beat(KIND_FREE_ALL, '0);
      send_beat(KIND_ALLOC, '0);
      send_beat(KIND_ALLOC, '0);
      send_beat(KIND_ALLOC, '0);
      send_beat(KIND_FREE, 24'd127);
      send_beat(KIND_FREE, 24'd128);
      send_beat(KIND_FREE, 24'd0);
      send_beat(KIND_FREE, 24'd0);
      send_beat(KIND_ALLOC, '0);
      send_beat(KIND_ALLOC, '0);
      send_beat(KIND_ALLOC, '0);
   endtask

   // Length far above the link storage: count is capped, a free past it is rejected
   task automatic test_capped_pool();
      set_pool(25'd16777216, 5'd3);
      send_beat(KIND_FREE_ALL, '0);
      send_beat(KIND_FREE, 24'h0007FF);
      send_beat(KIND_FREE, 24'h000800);
      send_beat(KIND_ALLOC, '0);
      send_beat(KIND_ALLOC, '0);
   endtask

   // Mostly well-formed alloc/free traffic, plus bound probes and noise
   task automatic test_random_traffic(input logic [LENGTH_W-1:0] len,
                                      input logic [SHIFT_W-1:0] shift,
                                      input int idle_pct, input int stall_pct, input int n);
      set_pool(len, shift);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      run_traffic(n);
   endtask

   task automatic run_traffic(input int n);
      pool_result_type     res;
      logic [1:0]          kind;
      logic [OFFSET_W-1:0] off;
      logic [OFFSET_W-1:0] low_mask;
      int                  pick;
      int                  k;
      for (int i = 0; i < n; i++) begin
         low_mask = (OFFSET_W'(1) << clamp_chunk_shift(pool_cfg.chunk_shift)) - 1'b1;
         pick = $urandom_range(0, 99);
         kind = KIND_FREE;
         off = OFFSET_W'($urandom);
         if (pick < 40) begin
            kind = KIND_ALLOC;
         end else if (pick < 65 && held_chunks.size() > 0) begin
            // return a chunk we hold, anywhere inside it
            k = $urandom_range(0, held_chunks.size() - 1);
            off = held_chunks[k] | (OFFSET_W'($urandom) & low_mask);
            freed_chunks.push_back(held_chunks[k]);
            held_chunks.delete(k);
         end else if (pick < 72 && freed_chunks.size() > 0) begin
            off = freed_chunks[$urandom_range(0, freed_chunks.size() - 1)];
         end else if (pick < 80) begin
            off = OFFSET_W'(int'(pool_cfg.buffer_length) + $urandom_range(0, 4) - 2);
         end else if (pick < 86) begin
            // fully random offset
         end else if (pick < 91) begin
            kind = KIND_FREE_ALL;
         end else if (pick < 94) begin
            kind = KIND_UNUSED;
         end else if (pool_cfg.buffer_length != 0) begin
            off = OFFSET_W'($urandom_range(0, int'(pool_cfg.buffer_length) - 1));
         end
         send_item(kind, off, res);
         if (kind == KIND_ALLOC && res.status == STATUS_OK) begin
            held_chunks.push_back(res.chunk_offset);
         end
         if (kind == KIND_FREE_ALL) begin
            held_chunks.delete();
         end
         if (freed_chunks.size() > 8) begin
            void'(freed_chunks.pop_front());
         end
      end
   endtask

   // Sink holds off for a long stretch while requests keep coming
   task automatic test_backpressure();
      wait_quiet();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_left = 400;
      run_traffic(40);
   endtask

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.kind        = KIND_ALLOC;
      req_ch.byte_offset = '0;
      rsp_ch.ready       = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_pool();
      test_small_pool();
      test_capped_pool();
      test_random_traffic(25'd2048, 5'd3, 0, 0, 150);
      test_random_traffic(25'd16777216, 5'd16, 78, 0, 150);
      test_random_traffic(25'd100, 5'd0, 0, 78, 150);
      test_random_traffic(25'd16777215, 5'd31, 29, 29, 150);
      test_random_traffic(25'd40000, 5'd5, 0, 0, 150);
      test_backpressure();
      test_random_traffic(25'd0, 5'd10, 29, 29, 60);

      wait_quiet();
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
